// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int unsigned PRI_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 5;

  // Operation codes on the input channel
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  // Per-cell control, built by the top level for each slot
  typedef struct packed {
    logic en;          // an item updates the queue this cycle
    logic ins;         // insert (1) or remove (0)
    logic valid;       // this slot holds an entry
    logic valid_left;  // left neighbor holds an entry (head: always 1)
    logic gt_left;     // left neighbor's priority is above the new one
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
  input  wire logic                       clk_i,
  input  wire spq_pkg::spq_ctrl_t         ctrl_i,
  input  wire logic [spq_pkg::PRI_W-1:0]  new_pri_i,
  input  wire logic [spq_pkg::VAL_W-1:0]  new_val_i,
  input  wire logic [spq_pkg::PRI_W-1:0]  left_pri_i,
  input  wire logic [spq_pkg::VAL_W-1:0]  left_val_i,
  input  wire logic [spq_pkg::PRI_W-1:0]  right_pri_i,
  input  wire logic [spq_pkg::VAL_W-1:0]  right_val_i,
  output logic      [spq_pkg::PRI_W-1:0]  pri_o,
  output logic      [spq_pkg::VAL_W-1:0]  val_o,
  output logic                            gt_o
);
  import spq_pkg::*;

  logic [PRI_W-1:0] pri_q, pri_d;
  logic [VAL_W-1:0] val_q, val_d;

  // Stored entry sits behind the new one if its priority is strictly larger
  assign gt_o = ctrl_i.valid && (pri_q > new_pri_i);

  // Shift right, load new, shift left or hold
  always_comb begin
    pri_d = pri_q;
    val_d = val_q;
    if (ctrl_i.en) begin
      if (ctrl_i.ins) begin
        if (ctrl_i.gt_left) begin
          pri_d = left_pri_i;
          val_d = left_val_i;
        end else if (ctrl_i.valid_left && (gt_o || !ctrl_i.valid)) begin
          pri_d = new_pri_i;
          val_d = new_val_i;
        end
      end else begin
        pri_d = right_pri_i;
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    val_q <= val_d;
  end

  assign pri_o = pri_q;
  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
`default_nettype none

// Sorted priority queue, smallest priority first, equal priorities in arrival order.
// Input channel (valid_i/ready_o): op_i selects insert or remove; an insert carries
// priority_req_i and value_i. Output channel (valid_o/ready_i): one result per item
// with status_o, out_priority_o/out_value_o (removed entry, else zero) and
// occupancy_o (entries held after the item).
// Storage is a row of CAPACITY cells; every cell compares its priority with the
// incoming one and shifts right, loads, shifts left or holds.
// Latency: the result appears in the cycle after the item is accepted.
// Throughput: one item per cycle, set by the single output register; ready_o is
// high whenever that register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and ready_o drops until it is taken.
// An insert into a full queue is dropped and reported as full; a remove from an
// empty queue reports empty. Reset empties the queue and the output register.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic                              op_i,
  input  wire logic        [spq_pkg::PRI_W-1:0]  priority_req_i,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  value_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output logic             [1:0]                 status_o,
  output logic             [spq_pkg::PRI_W-1:0]  out_priority_o,
  output logic signed      [spq_pkg::VAL_W-1:0]  out_value_o,
  output logic             [spq_pkg::OCC_W-1:0]  occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic              accept;
  logic              is_ins;
  logic              full;
  logic              empty;
  logic              upd;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [PRI_W-1:0]  cell_pri [CAPACITY];
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_valid;
  spq_ctrl_t         cell_ctrl [CAPACITY];

  logic              out_valid_q;
  spq_status_e       status_q, status_d;
  logic [PRI_W-1:0]  opri_q, opri_d;
  logic [VAL_W-1:0]  oval_q, oval_d;
  logic [CNT_W-1:0]  occ_q;

  assign ready_o = !out_valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign is_ins  = (op_i == OP_INSERT);
  assign full    = (count_q == CAP);
  assign empty   = (count_q == '0);
  assign upd     = accept && (is_ins ? !full : !empty);

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = (CNT_W'(i) < count_q);

    always_comb begin
      cell_ctrl[i].en    = upd;
      cell_ctrl[i].ins   = is_ins;
      cell_ctrl[i].valid = cell_valid[i];
      if (i == 0) begin
        cell_ctrl[i].valid_left = 1'b1;
        cell_ctrl[i].gt_left    = 1'b0;
      end else begin
        cell_ctrl[i].valid_left = cell_valid[(i == 0) ? 0 : i - 1];
        cell_ctrl[i].gt_left    = cell_gt[(i == 0) ? 0 : i - 1];
      end
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .new_pri_i   (priority_req_i),
      .new_val_i   (value_i),
      .left_pri_i  (cell_pri[(i == 0) ? 0 : i - 1]),
      .left_val_i  (cell_val[(i == 0) ? 0 : i - 1]),
      .right_pri_i (cell_pri[(i == CAPACITY - 1) ? i : i + 1]),
      .right_val_i (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .pri_o       (cell_pri[i]),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (upd) begin
      count_d = is_ins ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  // Result fields
  always_comb begin
    opri_d = '0;
    oval_d = '0;
    if (is_ins) begin
      status_d = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_REMOVED;
      opri_d   = cell_pri[0];
      oval_d   = cell_val[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      opri_q   <= opri_d;
      oval_q   <= oval_d;
      occ_q    <= count_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = opri_q;
  assign out_value_o    = oval_q;
  assign occupancy_o    = OCC_W'(occ_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("accepted insert did not grow the queue");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_pri[0] <= cell_pri[1]))
    else $error("head entry out of priority order");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && full) |=> (status_q == ST_FULL && count_q == CAP))
    else $error("insert into full queue not dropped");

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_test.sv =====
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int DIR_N = 25;
  localparam int RAND_PHASES = 15;
  localparam int PHASE_LEN = 100;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    spq_status_e              status;
    logic [PRI_W-1:0]         pri;
    logic signed [VAL_W-1:0]  val;
    logic [OCC_W-1:0]         occ;
  } spq_result_t;

  typedef struct packed {
    logic                     op;
    logic [PRI_W-1:0]         pri;
    logic [VAL_W-1:0]         val;
    logic                     pinned;   // result typed in below
    spq_result_t              res;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     valid_i = 1'b0;
  logic                     ready_o;
  logic                     op_i = OP_INSERT;
  logic [PRI_W-1:0]         priority_req_i = '0;
  logic signed [VAL_W-1:0]  value_i = '0;
  logic                     valid_o;
  logic                     ready_i = 1'b0;
  logic [1:0]               status_o;
  logic [PRI_W-1:0]         out_priority_o;
  logic signed [VAL_W-1:0]  out_value_o;
  logic [OCC_W-1:0]         occupancy_o;

  sorted_priority_queue #(.CAPACITY(DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .ready_o        (ready_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .ready_i        (ready_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_value_o    (out_value_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the queue contents, head at index 0
  logic [PRI_W-1:0]         shadow_pri [DEPTH];
  logic signed [VAL_W-1:0]  shadow_val [DEPTH];
  int unsigned              shadow_cnt = 0;

  spq_result_t  pending_q [$];
  dir_row_t     dir_tab [DIR_N];
  int           n_taken = 0;
  int           n_checked = 0;
  int           n_errors = 0;
  int           tally [4] = '{0, 0, 0, 0};
  int           burst_left = 0;

  // Apply one item to the shadow queue and return the result it should produce
  function automatic spq_result_t queue_apply(logic op, logic [PRI_W-1:0] pri,
                                              logic signed [VAL_W-1:0] val);
    spq_result_t r;
    int unsigned pos;
    r = '{ST_INSERTED, '0, '0, '0};
    if (op == OP_INSERT) begin
      if (shadow_cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // after every stored entry of lower or equal priority
        pos = 0;
        while (pos < shadow_cnt && shadow_pri[pos] <= pri) pos++;
        for (int unsigned i = shadow_cnt; i > pos; i--) begin
          shadow_pri[i] = shadow_pri[i-1];
          shadow_val[i] = shadow_val[i-1];
        end
        shadow_pri[pos] = pri;
        shadow_val[pos] = val;
        shadow_cnt++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.pri = shadow_pri[0];
        r.val = shadow_val[0];
        for (int unsigned i = 1; i < shadow_cnt; i++) begin
          shadow_pri[i-1] = shadow_pri[i];
          shadow_val[i-1] = shadow_val[i];
        end
        shadow_cnt--;
      end
    end
    r.occ = shadow_cnt[OCC_W-1:0];
    return r;
  endfunction

  // Scoreboard: check results against the oldest expectation, then log new items
  always @(posedge clk_i) begin : scoreboard
    spq_result_t want;
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result with no item pending: status %0d occupancy %0d",
                 status_o, occupancy_o);
          n_errors++;
        end else begin
          want = pending_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (out_priority_o !== want.pri) begin
            $error("out_priority: expected %0d, got %0d", want.pri, out_priority_o);
            n_errors++;
          end
          if (out_value_o !== want.val) begin
            $error("out_value: expected %0d, got %0d", want.val, out_value_o);
            n_errors++;
          end
          if (occupancy_o !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
            n_errors++;
          end
          n_checked++;
          tally[want.status]++;
        end
      end
      if (valid_i && ready_o) begin
        want = queue_apply(op_i, priority_req_i, value_i);
        if (n_taken < DIR_N && dir_tab[n_taken].pinned) want = dir_tab[n_taken].res;
        pending_q.push_back(want);
        n_taken++;
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip, and one-in-three patterns
  initial begin : receiver
    int mode;
    int span;
    bit held_long;
    held_long = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      for (int c = 0; c < span; c++) begin
        if (!held_long && n_checked >= 400) begin
          // long hold-off so the output backs up and the input stalls
          ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          held_long = 1'b1;
        end
        case (mode)
          0: ready_i <= 1'b1;
          1: ready_i <= 1'($urandom_range(0, 1));
          default: ready_i <= (c % 3 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offer one item and hold it until accepted; bursts with random gaps
  task automatic offer_item(logic op, logic [PRI_W-1:0] pri, logic [VAL_W-1:0] val);
    int gap;
    op_i <= op;
    priority_req_i <= pri;
    value_i <= val;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (!ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Stop offering until every pending result has come back
  task automatic wait_drained();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  initial begin : stimulus
    int ins_pct;
    logic op;
    logic [PRI_W-1:0] pri;
    dir_tab = '{
      // removes and inserts at the extremes, equal priorities leave in order
      '{OP_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 8'd0, 32'sd0, 5'd0}},
      '{OP_INSERT, 8'd255, 32'h8000_0000, 1'b1, '{ST_INSERTED, 8'd0, 32'sd0, 5'd1}},
      '{OP_INSERT, 8'd0, 32'h7FFF_FFFF, 1'b1, '{ST_INSERTED, 8'd0, 32'sd0, 5'd2}},
      '{OP_INSERT, 8'd0, 32'h0000_0001, 1'b1, '{ST_INSERTED, 8'd0, 32'sd0, 5'd3}},
      '{OP_REMOVE, 8'h55, 32'h1234_5678, 1'b1,
        '{ST_REMOVED, 8'd0, 32'sh7FFF_FFFF, 5'd2}},
      '{OP_REMOVE, 8'd0, 32'd0, 1'b1, '{ST_REMOVED, 8'd0, 32'sd1, 5'd1}},
      '{OP_REMOVE, 8'd0, 32'd0, 1'b1,
        '{ST_REMOVED, 8'd255, 32'sh8000_0000, 5'd0}},
      '{OP_REMOVE, 8'hAA, 32'hAAAA_AAAA, 1'b1, '{ST_EMPTY, 8'd0, 32'sd0, 5'd0}},
      // fill to capacity with mixed and repeated priorities
      '{OP_INSERT, 8'd200, 32'h0000_0000, 1'b0, '0},
      '{OP_INSERT, 8'd50, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_INSERT, 8'd50, 32'h5555_5555, 1'b0, '0},
      '{OP_INSERT, 8'd255, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_INSERT, 8'd0, 32'h8000_0000, 1'b0, '0},
      '{OP_INSERT, 8'd100, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_INSERT, 8'd50, 32'h0000_0001, 1'b0, '0},
      '{OP_INSERT, 8'd7, 32'hDEAD_BEEF, 1'b0, '0},
      '{OP_INSERT, 8'd0, 32'h0F0F_0F0F, 1'b0, '0},
      '{OP_INSERT, 8'd255, 32'hF0F0_F0F0, 1'b0, '0},
      '{OP_INSERT, 8'd128, 32'h0000_FFFF, 1'b0, '0},
      '{OP_INSERT, 8'd1, 32'hFFFF_0000, 1'b0, '0},
      '{OP_INSERT, 8'd254, 32'h3333_3333, 1'b0, '0},
      '{OP_INSERT, 8'd64, 32'hCCCC_CCCC, 1'b0, '0},
      '{OP_INSERT, 8'd50, 32'h0000_0002, 1'b0, '0},
      '{OP_INSERT, 8'd3, 32'hFFFF_FFFE, 1'b0, '0},
      // insert into a full queue is dropped
      '{OP_INSERT, 8'd0, 32'h1111_1111, 1'b1, '{ST_FULL, 8'd0, 32'sd0, 5'd16}}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) offer_item(dir_tab[i].op, dir_tab[i].pri, dir_tab[i].val);
    wait_drained();

    // Random phases, each leaning toward filling, draining, or balance
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        // mostly a narrow priority band so ties are common
        pri = ($urandom_range(0, 3) != 0) ? PRI_W'($urandom_range(0, 7))
                                          : PRI_W'($urandom_range(0, 255));
        offer_item(op, pri, $urandom);
      end
      if (ph % 5 == 4) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("items %0d, results checked %0d", n_taken, n_checked);
    $display("inserted %0d, removed %0d, empty %0d, full drops %0d",
             tally[ST_INSERTED], tally[ST_REMOVED], tally[ST_EMPTY], tally[ST_FULL]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("timeout with %0d results pending", pending_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
